// ----- hw/rtl/sci_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sci_pkg
// shared constants and types of the section crossing interpolator
// ----------------------------------------------------------------------------
package sci_pkg;

  localparam int VALUE_BITS_DEFAULT = 32;
  localparam int TRAJ_BITS          = 12;
  localparam int NUM_VALUES         = 7;
  localparam int NUM_COMPONENTS     = 6;
  localparam int COMP_BITS          = 3;
  localparam int CFG_INDEX_BITS     = 2;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SECTION_COMPONENT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SECTION_LEVEL     = 2'd1;

  // reset value of the component selector: y
  localparam logic [COMP_BITS-1:0] COMPONENT_RESET = 3'd1;

  // sequencer to interpolation lanes
  typedef struct packed {
    logic load;   // capture endpoints, form |c - p|
    logic step;   // one shift-add step of the fraction multiply
    logic qbit;   // quotient bit for this step, lsb first
    logic fin;    // apply the rounded offset to p
  } lane_ctrl_t;

endpackage

// ----- hw/rtl/sci_sample_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sci_sample_if
// trajectory sample channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface sci_sample_if #(
  parameter int VALUE_BITS = sci_pkg::VALUE_BITS_DEFAULT
);
  logic                          valid;
  logic                          ready;
  logic [VALUE_BITS-1:0]         pos_x;
  logic [VALUE_BITS-1:0]         pos_y;
  logic [VALUE_BITS-1:0]         pos_z;
  logic [VALUE_BITS-1:0]         vel_x;
  logic [VALUE_BITS-1:0]         vel_y;
  logic [VALUE_BITS-1:0]         vel_z;
  logic [VALUE_BITS-1:0]         sample_time;
  logic                          first_sample;
  logic [sci_pkg::TRAJ_BITS-1:0] trajectory_id;

  modport source (
    output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, sample_time,
           first_sample, trajectory_id,
    input  ready
  );

  modport sink (
    input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, sample_time,
           first_sample, trajectory_id,
    output ready
  );
endinterface

// ----- hw/rtl/sci_hit_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sci_hit_if
// section crossing result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface sci_hit_if #(
  parameter int VALUE_BITS = sci_pkg::VALUE_BITS_DEFAULT
);
  logic                          valid;
  logic                          ready;
  logic [VALUE_BITS-1:0]         hit_pos_x;
  logic [VALUE_BITS-1:0]         hit_pos_y;
  logic [VALUE_BITS-1:0]         hit_pos_z;
  logic [VALUE_BITS-1:0]         hit_vel_x;
  logic [VALUE_BITS-1:0]         hit_vel_y;
  logic [VALUE_BITS-1:0]         hit_vel_z;
  logic [VALUE_BITS-1:0]         crossing_time;
  logic                          rising;
  logic [sci_pkg::TRAJ_BITS-1:0] hit_trajectory;

  modport source (
    output valid, hit_pos_x, hit_pos_y, hit_pos_z, hit_vel_x, hit_vel_y, hit_vel_z,
           crossing_time, rising, hit_trajectory,
    input  ready
  );

  modport sink (
    input  valid, hit_pos_x, hit_pos_y, hit_pos_z, hit_vel_x, hit_vel_y, hit_vel_z,
           crossing_time, rising, hit_trajectory,
    output ready
  );
endinterface

// ----- hw/rtl/sci_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sci_divider
// restoring fraction divider, floor(n * 2^W / den) for n < den, one bit a cycle
// ----------------------------------------------------------------------------
module sci_divider #(
  parameter int VALUE_BITS = sci_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] numer,
  input  logic [VALUE_BITS-1:0] denom,
  output logic [VALUE_BITS-1:0] quotient,
  output logic                  done
);
  localparam int CW = $clog2(VALUE_BITS);

  logic                  busy;
  logic [CW-1:0]         cnt;
  logic [VALUE_BITS-1:0] rem;
  logic [VALUE_BITS-1:0] den_r;
  logic [VALUE_BITS:0]   shifted;
  logic [VALUE_BITS:0]   diff;
  logic                  ge;

  assign shifted = {rem, 1'b0};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(VALUE_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= numer;
      den_r    <= denom;
      quotient <= '0;
    end else if (busy) begin
      rem      <= ge ? diff[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
      quotient <= {quotient[VALUE_BITS-2:0], ge};
    end
  end
endmodule

// ----- hw/rtl/sci_mac_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sci_mac_lane
// one interpolation lane: p + sign(c - p) * round(|c - p| * q / 2^W)
// ----------------------------------------------------------------------------
module sci_mac_lane #(
  parameter int VALUE_BITS = sci_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  sci_pkg::lane_ctrl_t   ctrl,
  input  logic [VALUE_BITS-1:0] p,
  input  logic [VALUE_BITS-1:0] c,
  output logic [VALUE_BITS-1:0] result
);
  logic [VALUE_BITS-1:0] p_r;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg;
  logic [VALUE_BITS-1:0] acc;
  logic                  half;
  logic [VALUE_BITS:0]   d_cp;
  logic [VALUE_BITS:0]   d_pc;
  logic [VALUE_BITS:0]   sum;
  logic [VALUE_BITS-1:0] carry_in;

  // both differences side by side, sign picks the magnitude
  assign d_cp = {c[VALUE_BITS-1], c} - {p[VALUE_BITS-1], p};
  assign d_pc = {p[VALUE_BITS-1], p} - {c[VALUE_BITS-1], c};
  assign sum  = {1'b0, acc} + (ctrl.qbit ? {1'b0, mag} : '0);

  // rounding bit enters as carry; subtract path uses p + ~acc + !half
  assign carry_in = {{(VALUE_BITS-1){1'b0}}, neg ? ~half : half};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      p_r  <= p;
      neg  <= d_cp[VALUE_BITS];
      mag  <= d_cp[VALUE_BITS] ? d_pc[VALUE_BITS-1:0] : d_cp[VALUE_BITS-1:0];
      acc  <= '0;
      half <= 1'b0;
    end else if (ctrl.step) begin
      acc  <= sum[VALUE_BITS:1];
      half <= sum[0];
    end else if (ctrl.fin) begin
      result <= p_r + (neg ? ~acc : acc) + carry_in;
    end
  end
endmodule

// ----- hw/rtl/section_crossing_interpolator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// section_crossing_interpolator_core
// finds where a sampled trajectory crosses a section plane and interpolates it
// ----------------------------------------------------------------------------
// path: an interpolated crossing passes setup, decide, the divider, the lanes' shift-add
//   multiply and their finish before the output stage; a hit on the stored or current sample
//   goes from decide straight to the output stage
// requests: a new one is taken only in idle, once the last result is in the output register
// a finished result waits in the output register while the next request enters
// reset: synchronous, clears the sequencer, no previous sample, selector y, level 0
module section_crossing_interpolator_core #(
  parameter int VALUE_BITS = sci_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [sci_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [VALUE_BITS-1:0]              cfg_data,
  sci_sample_if.sink                         samples,
  sci_hit_if.source                          hits
);
  localparam int NV = sci_pkg::NUM_VALUES;
  localparam int CW = $clog2(VALUE_BITS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_DECIDE, ST_DIV, ST_MUL, ST_FIN, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    SRC_PREV, SRC_CUR, SRC_LANE
  } src_t;

  // configuration
  logic [sci_pkg::COMP_BITS-1:0] section_component;
  logic [VALUE_BITS-1:0]         section_level;

  // sample store and working copies
  logic [VALUE_BITS-1:0] in_vals     [NV];
  logic [VALUE_BITS-1:0] prev_sample [NV];
  logic [VALUE_BITS-1:0] work_p      [NV];
  logic [VALUE_BITS-1:0] work_c      [NV];
  logic [VALUE_BITS-1:0] lane_result [NV];
  logic                  prev_valid;
  logic                  cmp_en;
  logic [sci_pkg::TRAJ_BITS-1:0] traj;

  // sequencer
  state_t                state;
  src_t                  src;
  logic [CW-1:0]         cnt;
  logic [VALUE_BITS-1:0] q_shift;
  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] quotient;
  sci_pkg::lane_ctrl_t   lane_ctrl;

  // differences against the level and c - p, one extra bit so nothing wraps
  logic [sci_pkg::COMP_BITS-1:0] k;
  logic [VALUE_BITS-1:0] cp;
  logic [VALUE_BITS-1:0] cc;
  logic [VALUE_BITS:0]   vp_d;
  logic [VALUE_BITS:0]   vc_d;
  logic [VALUE_BITS:0]   dd;
  logic [VALUE_BITS-1:0] n_mag;
  logic [VALUE_BITS-1:0] den_mag;
  logic                  vp_zero;
  logic                  vc_zero;
  logic                  vp_neg;
  logic                  vc_neg;
  logic                  crossing;

  // result register
  logic                  hit_valid;
  logic [VALUE_BITS-1:0] hit_vals [NV];
  logic                  hit_rising;
  logic                  rising_r;
  logic [sci_pkg::TRAJ_BITS-1:0] hit_traj;
  logic                  accept;
  logic                  out_free;

  assign accept   = samples.valid && samples.ready;
  assign out_free = !hit_valid || hits.ready;
  assign samples.ready = (state == ST_IDLE);

  assign in_vals[0] = samples.pos_x;
  assign in_vals[1] = samples.pos_y;
  assign in_vals[2] = samples.pos_z;
  assign in_vals[3] = samples.vel_x;
  assign in_vals[4] = samples.vel_y;
  assign in_vals[5] = samples.vel_z;
  assign in_vals[6] = samples.sample_time;

  assign hits.valid          = hit_valid;
  assign hits.hit_pos_x      = hit_vals[0];
  assign hits.hit_pos_y      = hit_vals[1];
  assign hits.hit_pos_z      = hit_vals[2];
  assign hits.hit_vel_x      = hit_vals[3];
  assign hits.hit_vel_y      = hit_vals[4];
  assign hits.hit_vel_z      = hit_vals[5];
  assign hits.crossing_time  = hit_vals[6];
  assign hits.rising         = hit_rising;
  assign hits.hit_trajectory = hit_traj;

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      section_component <= sci_pkg::COMPONENT_RESET;
      section_level     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sci_pkg::CFG_SECTION_COMPONENT: section_component <= cfg_data[sci_pkg::COMP_BITS-1:0];
        sci_pkg::CFG_SECTION_LEVEL:     section_level     <= cfg_data;
        default: ;
      endcase
    end
  end

  // selected component; unused selector codes never compare (cmp_en)
  assign k  = (section_component < sci_pkg::COMP_BITS'(sci_pkg::NUM_COMPONENTS))
              ? section_component : '0;
  assign cp = work_p[k];
  assign cc = work_c[k];

  // decide-stage view of the registered differences
  assign vp_zero  = (vp_d == '0);
  assign vc_zero  = (vc_d == '0);
  assign vp_neg   = vp_d[VALUE_BITS];
  assign vc_neg   = vc_d[VALUE_BITS];
  assign n_mag    = vp_neg ? VALUE_BITS'(~vp_d + 1'b1) : vp_d[VALUE_BITS-1:0];
  assign den_mag  = dd[VALUE_BITS] ? VALUE_BITS'(~dd + 1'b1) : dd[VALUE_BITS-1:0];
  // strictly opposite sides, or current sample lands on the section
  assign crossing = !vp_zero && (vc_zero || (vc_neg != vp_neg));

  assign div_start = (state == ST_DECIDE) && cmp_en && crossing && (den_mag != '0)
                     && (n_mag < den_mag);

  always_comb begin
    lane_ctrl.load = div_start;
    lane_ctrl.step = (state == ST_MUL);
    lane_ctrl.qbit = q_shift[0];
    lane_ctrl.fin  = (state == ST_FIN);
  end

  // sample capture; the stored sample is payload and needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < NV; i++) begin
        work_p[i]      <= prev_sample[i];
        work_c[i]      <= in_vals[i];
        prev_sample[i] <= in_vals[i];
      end
      traj <= samples.trajectory_id;
    end
    if (state == ST_SETUP) begin
      vp_d <= {cp[VALUE_BITS-1], cp} - {section_level[VALUE_BITS-1], section_level};
      vc_d <= {cc[VALUE_BITS-1], cc} - {section_level[VALUE_BITS-1], section_level};
      dd   <= {cc[VALUE_BITS-1], cc} - {cp[VALUE_BITS-1], cp};
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      prev_valid <= 1'b0;
      cmp_en     <= 1'b0;
      hit_valid  <= 1'b0;
      src        <= SRC_PREV;
      rising_r   <= 1'b0;
      cnt        <= '0;
      q_shift    <= '0;
    end else begin
      // output register fills from a free slot, empties when the result is taken
      if (state == ST_OUT && out_free) begin
        hit_valid <= 1'b1;
      end else if (hits.ready) begin
        hit_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cmp_en     <= !samples.first_sample && prev_valid
                          && (section_component < sci_pkg::COMP_BITS'(sci_pkg::NUM_COMPONENTS));
            prev_valid <= 1'b1;
            state      <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (!cmp_en) begin
            state <= ST_IDLE;
          end else if (vp_zero && !vc_zero) begin
            // previous sample sits on the section
            src      <= SRC_PREV;
            rising_r <= !vc_neg;
            state    <= ST_OUT;
          end else if (crossing && (den_mag != '0)) begin
            rising_r <= vp_neg;
            if (n_mag >= den_mag) begin
              // alpha is one: the current sample is the hit
              src   <= SRC_CUR;
              state <= ST_OUT;
            end else begin
              src   <= SRC_LANE;
              state <= ST_DIV;
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            q_shift <= quotient;
            cnt     <= '0;
            state   <= ST_MUL;
          end
        end
        ST_MUL: begin
          q_shift <= q_shift >> 1;
          cnt     <= cnt + 1'b1;
          if (cnt == CW'(VALUE_BITS - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      for (int i = 0; i < NV; i++) begin
        case (src)
          SRC_PREV: hit_vals[i] <= work_p[i];
          SRC_CUR:  hit_vals[i] <= work_c[i];
          default:  hit_vals[i] <= lane_result[i];
        endcase
      end
      hit_rising <= rising_r;
      hit_traj   <= traj;
    end
  end

  sci_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (n_mag),
    .denom    (den_mag),
    .quotient (quotient),
    .done     (div_done)
  );

  // seven lanes share the quotient bit stream
  for (genvar g = 0; g < NV; g++) begin : g_lane
    sci_mac_lane #(
      .VALUE_BITS(VALUE_BITS)
    ) u_lane (
      .clk    (clk),
      .ctrl   (lane_ctrl),
      .p      (work_p[g]),
      .c      (work_c[g]),
      .result (lane_result[g])
    );
  end

  // divider finishes only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the divide phase");

  // divide phase hands over to the multiply phase
  a_div_to_mul: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_done) |=> (state == ST_MUL))
    else $error("multiply phase did not follow the quotient");

  // lanes finish only after the full multiply phase
  a_fin_after_mul: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |-> ($past(state) == ST_MUL && $past(cnt) == CW'(VALUE_BITS - 1)))
    else $error("lane finish without a complete multiply");

  // a taken request is always examined next
  a_accept_setup: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SETUP))
    else $error("request not examined after acceptance");
endmodule
